/* src/linear_interp_resampler_peak_meter_defines.svh */
// Assertion macros for the resampler and peak meter.
`ifndef LINEAR_INTERP_RESAMPLER_PEAK_METER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_PEAK_METER_DEFINES_SVH

// Same-cycle implication.
`define LIRPM_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LIRPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lirpm_pkg.sv */
package lirpm_pkg;

    localparam int OUTPUT_RATE_DEF = 48000;
    localparam int RATE_W          = 20;
    localparam int RATE_RESET      = 48000;
    localparam int RATE_MIN        = 8000;
    localparam int RATE_MAX        = 655350;
    localparam int PHASE_W         = 21;
    localparam int SAMPLE_W        = 16;
    localparam int COUNT_W         = 40;
    localparam int MAX_PAIRS       = 6;
    localparam int PAIR_CNT_W      = $clog2(MAX_PAIRS + 1);
    localparam int S_TDATA_W       = 32;
    localparam int M_FIELDS_W      = 4 * SAMPLE_W + COUNT_W + 1;
    localparam int M_TDATA_W       = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic KIND_PAIR  = 1'b0;
    localparam logic KIND_METER = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

    // Magnitude of a 16-bit sample; the most negative code gives 32768.
    function automatic logic [SAMPLE_W-1:0] abs_sample(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] neg;
        neg = ~v + 1'b1;
        return v[SAMPLE_W-1] ? neg : v;
    endfunction

endpackage

/* src/linear_interp_resampler_peak_meter.sv */
// Stereo linear-interpolation resampler with peak meter. A beat on s_ with
// s_tuser low is a 16-bit sample pair at the rate written through cfg_wr_*;
// it yields zero to six interpolated pairs at OUTPUT_RATE on m_, the last
// marked by m_tlast. A beat with s_tuser high yields one meter report (peaks
// since the last report, then cleared). Items are handled one at a time.
// Each output pair is computed by two bit-serial lanes, a shift-add
// multiply and a restoring divide, clog2(OUTPUT_RATE) + 16 steps in all.
// An out-of-range rate sets a sticky error flag, cleared only by reset,
// that silences all pair output.
`include "linear_interp_resampler_peak_meter_defines.svh"

module linear_interp_resampler_peak_meter #(
    parameter int OUTPUT_RATE = lirpm_pkg::OUTPUT_RATE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lirpm_pkg::RATE_W-1:0]       cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lirpm_pkg::S_TDATA_W-1:0]    s_tdata,   // left_sample, right_sample
    input  logic                               s_tuser,   // action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_left, out_right, peak_left_level, peak_right_level, frames_played,
    // error_flag, zero pad
    output logic [lirpm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tuser,   // result_kind
    output logic                               m_tlast
);

    localparam int SW      = lirpm_pkg::SAMPLE_W;
    localparam int PW      = lirpm_pkg::PHASE_W;
    localparam int PH_W    = $clog2(OUTPUT_RATE);
    localparam int NW      = lirpm_pkg::PAIR_CNT_W;
    localparam logic [PW-1:0] OUT_RATE_C = PW'(OUTPUT_RATE);
    localparam logic [NW-1:0] MAX_C      = NW'(lirpm_pkg::MAX_PAIRS);
    localparam logic [NW-1:0] LAST_C     = NW'(lirpm_pkg::MAX_PAIRS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_METER = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [lirpm_pkg::RATE_W-1:0]       rate_reg, rate_next;
    logic                               hist_valid_reg, hist_valid_next;
    logic [SW-1:0]                      hist_l_reg, hist_l_next;
    logic [SW-1:0]                      hist_r_reg, hist_r_next;
    logic [SW-1:0]                      cur_l_reg, cur_l_next;
    logic [SW-1:0]                      cur_r_reg, cur_r_next;
    logic [PW-1:0]                      phase_reg, phase_next;
    logic [NW-1:0]                      pairs_reg, pairs_next;
    logic [SW-1:0]                      peak_l_reg, peak_l_next;
    logic [SW-1:0]                      peak_r_reg, peak_r_next;
    logic [lirpm_pkg::COUNT_W-1:0]      frames_reg, frames_next;
    logic                               rate_error_reg, rate_error_next;

    logic                               m_valid_reg;
    logic                               o_kind_reg;
    logic                               o_last_reg;
    logic [SW-1:0]                      o_left_reg;
    logic [SW-1:0]                      o_right_reg;
    logic [SW-1:0]                      o_peak_l_reg;
    logic [SW-1:0]                      o_peak_r_reg;
    logic [lirpm_pkg::COUNT_W-1:0]      o_frames_reg;
    logic                               o_err_reg;

    logic                               s_fire;
    logic                               out_free;
    logic                               load_pair;
    logic                               load_meter;
    logic                               rate_ok;
    logic                               phase_lt;
    logic [PW-1:0]                      phase_step;
    logic                               lane_start;
    logic [SW-1:0]                      mag_l;
    logic [SW-1:0]                      mag_r;
    logic [SW-1:0]                      peak_l_upd;
    logic [SW-1:0]                      peak_r_upd;
    logic [lirpm_pkg::COUNT_W-1:0]      frames_inc;
    logic                               pair_last;

    lirpm_pkg::lane_stat_t              lane_l_stat;
    lirpm_pkg::lane_stat_t              lane_r_stat;
    logic signed [SW-1:0]               lane_l_res;
    logic signed [SW-1:0]               lane_r_res;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign rate_ok    = (rate_reg >= lirpm_pkg::RATE_W'(lirpm_pkg::RATE_MIN)) &&
                        (rate_reg <= lirpm_pkg::RATE_W'(lirpm_pkg::RATE_MAX));
    assign phase_lt   = phase_reg < OUT_RATE_C;
    assign phase_step = phase_reg + PW'(rate_reg);
    assign lane_start = (state_reg == ST_CHECK) && phase_lt && (pairs_reg < MAX_C);
    assign mag_l      = lirpm_pkg::abs_sample(lane_l_res);
    assign mag_r      = lirpm_pkg::abs_sample(lane_r_res);
    assign peak_l_upd = (mag_l > peak_l_reg) ? mag_l : peak_l_reg;
    assign peak_r_upd = (mag_r > peak_r_reg) ? mag_r : peak_r_reg;
    assign frames_inc = frames_reg + 1'b1;
    assign pair_last  = (phase_step >= OUT_RATE_C) || (pairs_reg == LAST_C);
    assign load_pair  = (state_reg == ST_EMIT) && out_free;
    assign load_meter = (state_reg == ST_METER) && out_free;

    lirpm_lerp_lane #(.OUTPUT_RATE(OUTPUT_RATE)) u_lane_l (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lane_start),
        .prev    (hist_l_reg),
        .cur     (cur_l_reg),
        .phase   (phase_reg[PH_W-1:0]),
        .stat    (lane_l_stat),
        .result  (lane_l_res)
    );

    lirpm_lerp_lane #(.OUTPUT_RATE(OUTPUT_RATE)) u_lane_r (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lane_start),
        .prev    (hist_r_reg),
        .cur     (cur_r_reg),
        .phase   (phase_reg[PH_W-1:0]),
        .stat    (lane_r_stat),
        .result  (lane_r_res)
    );

    always_comb begin
        state_next      = state_reg;
        rate_next       = rate_reg;
        hist_valid_next = hist_valid_reg;
        hist_l_next     = hist_l_reg;
        hist_r_next     = hist_r_reg;
        cur_l_next      = cur_l_reg;
        cur_r_next      = cur_r_reg;
        phase_next      = phase_reg;
        pairs_next      = pairs_reg;
        peak_l_next     = peak_l_reg;
        peak_r_next     = peak_r_reg;
        frames_next     = frames_reg;
        rate_error_next = rate_error_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == lirpm_pkg::KIND_METER) begin
                        state_next = ST_METER;
                    end else if (rate_error_reg) begin
                        state_next = ST_IDLE;
                    end else if (!rate_ok) begin
                        rate_error_next = 1'b1;
                    end else if (!hist_valid_reg) begin
                        hist_l_next     = s_tdata[SW-1:0];
                        hist_r_next     = s_tdata[2*SW-1:SW];
                        hist_valid_next = 1'b1;
                    end else begin
                        cur_l_next = s_tdata[SW-1:0];
                        cur_r_next = s_tdata[2*SW-1:SW];
                        pairs_next = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (!phase_lt) begin
                    phase_next  = phase_reg - OUT_RATE_C;
                    hist_l_next = cur_l_reg;
                    hist_r_next = cur_r_reg;
                    state_next  = ST_IDLE;
                end else if (pairs_reg < MAX_C) begin
                    state_next = ST_CALC;
                end else begin
                    // beyond the cap: phase moves on, nothing is emitted
                    phase_next = phase_step;
                end
            end
            ST_CALC: begin
                if (lane_l_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    peak_l_next = peak_l_upd;
                    peak_r_next = peak_r_upd;
                    frames_next = frames_inc;
                    phase_next  = phase_step;
                    pairs_next  = pairs_reg + 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_METER: begin
                if (out_free) begin
                    peak_l_next = '0;
                    peak_r_next = '0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            rate_next       = cfg_wr_data;
            hist_valid_next = 1'b0;
            phase_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rate_reg       <= lirpm_pkg::RATE_W'(lirpm_pkg::RATE_RESET);
            hist_valid_reg <= 1'b0;
            hist_l_reg     <= '0;
            hist_r_reg     <= '0;
            phase_reg      <= '0;
            pairs_reg      <= '0;
            peak_l_reg     <= '0;
            peak_r_reg     <= '0;
            frames_reg     <= '0;
            rate_error_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rate_reg       <= rate_next;
            hist_valid_reg <= hist_valid_next;
            hist_l_reg     <= hist_l_next;
            hist_r_reg     <= hist_r_next;
            phase_reg      <= phase_next;
            pairs_reg      <= pairs_next;
            peak_l_reg     <= peak_l_next;
            peak_r_reg     <= peak_r_next;
            frames_reg     <= frames_next;
            rate_error_reg <= rate_error_next;
            if (load_pair || load_meter) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_l_reg <= cur_l_next;
        cur_r_reg <= cur_r_next;
        if (load_pair) begin
            o_kind_reg   <= lirpm_pkg::KIND_PAIR;
            o_last_reg   <= pair_last;
            o_left_reg   <= lane_l_res;
            o_right_reg  <= lane_r_res;
            o_peak_l_reg <= peak_l_upd;
            o_peak_r_reg <= peak_r_upd;
            o_frames_reg <= frames_inc;
            o_err_reg    <= rate_error_reg;
        end else if (load_meter) begin
            o_kind_reg   <= lirpm_pkg::KIND_METER;
            o_last_reg   <= 1'b1;
            o_left_reg   <= '0;
            o_right_reg  <= '0;
            o_peak_l_reg <= peak_l_reg;
            o_peak_r_reg <= peak_r_reg;
            o_frames_reg <= frames_reg;
            o_err_reg    <= rate_error_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {{(lirpm_pkg::M_TDATA_W - lirpm_pkg::M_FIELDS_W){1'b0}}, o_err_reg,
                       o_frames_reg, o_peak_r_reg, o_peak_l_reg, o_right_reg, o_left_reg};

    `LIRPM_ASSERT(lanes_in_step, aclk, aresetn, 1'b1, lane_l_stat == lane_r_stat,
                  "lanes out of step")
    `LIRPM_ASSERT(meter_pair_zero, aclk, aresetn,
                  m_valid_reg && (o_kind_reg == lirpm_pkg::KIND_METER),
                  (o_left_reg == '0) && (o_right_reg == '0) && o_last_reg,
                  "bad meter report")
    `LIRPM_ASSERT_NEXT(error_sticky, aclk, aresetn, rate_error_reg, rate_error_reg,
                       "rate error cleared")
    `LIRPM_ASSERT(pair_cap, aclk, aresetn, state_reg == ST_EMIT, pairs_reg < MAX_C,
                  "pair cap exceeded")

endmodule

/* src/lirpm_lerp_lane.sv */
module lirpm_lerp_lane #(
    parameter int OUTPUT_RATE = lirpm_pkg::OUTPUT_RATE_DEF,
    localparam int PH_W = $clog2(OUTPUT_RATE)
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [lirpm_pkg::SAMPLE_W-1:0]  prev,
    input  logic signed [lirpm_pkg::SAMPLE_W-1:0]  cur,
    input  logic        [PH_W-1:0]                 phase,
    output lirpm_pkg::lane_stat_t                  stat,
    output logic signed [lirpm_pkg::SAMPLE_W-1:0]  result
);

    localparam int SW     = lirpm_pkg::SAMPLE_W;
    localparam int PROD_W = SW + PH_W;
    localparam int STEPS  = PH_W + SW;
    localparam int CNT_W  = $clog2(STEPS);
    localparam logic [PH_W:0] OUT_C = (PH_W + 1)'(OUTPUT_RATE);

    logic              busy_reg;
    logic              mul_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PH_W-1:0]   rem_reg;
    logic [SW-1:0]     mag_reg;
    logic              neg_reg;
    logic [SW-1:0]     prev_reg;
    logic [SW-1:0]     res_reg;

    logic [SW:0]       diff;
    logic [SW:0]       diff_neg;
    logic [SW-1:0]     mag;
    logic [SW:0]       sum;
    logic [PROD_W-1:0] mul_next;
    logic [PH_W:0]     trial;
    logic [PH_W:0]     trial_sub;
    logic              ge;
    logic [PH_W-1:0]   rem_next;
    logic [SW-1:0]     quot_next;

    assign diff      = {cur[SW-1], cur} - {prev[SW-1], prev};
    assign diff_neg  = ~diff + 1'b1;
    assign mag       = diff[SW] ? diff_neg[SW-1:0] : diff[SW-1:0];

    // shift-add multiply, one multiplier bit per cycle
    assign sum       = {1'b0, prod_reg[PROD_W-1:PH_W]} + (prod_reg[0] ? {1'b0, mag_reg} : '0);
    assign mul_next  = {sum, prod_reg[PH_W-1:1]};

    // restoring divide by the output rate, one quotient bit per cycle
    assign trial     = {rem_reg, prod_reg[SW-1]};
    assign ge        = trial >= OUT_C;
    assign trial_sub = trial - OUT_C;
    assign rem_next  = ge ? trial_sub[PH_W-1:0] : trial[PH_W-1:0];
    assign quot_next = {prod_reg[SW-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                mul_reg  <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(PH_W - 1)) begin
                    mul_reg <= 1'b0;
                end
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            prod_reg <= {{SW{1'b0}}, phase};
            mag_reg  <= mag;
            neg_reg  <= diff[SW];
            prev_reg <= prev;
        end else if (busy_reg && mul_reg) begin
            prod_reg <= mul_next;
            rem_reg  <= mul_next[PROD_W-1:SW];
        end else if (busy_reg) begin
            prod_reg[SW-1:0] <= quot_next;
            rem_reg          <= rem_next;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                res_reg <= neg_reg ? prev_reg - quot_next : prev_reg + quot_next;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule
